[sv/bounded_stack_queue_engine_macros.svh]
// Assertion macros used by the checker of the bounded stack and queue engine.
`ifndef BOUNDED_STACK_QUEUE_ENGINE_MACROS_SVH
`define BOUNDED_STACK_QUEUE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BSQE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BSQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bsqe_pkg.sv]
// Shared types and constants of the bounded stack and queue engine.
`timescale 1ns / 1ps
package bsqe_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CntW         = 7;
  localparam int unsigned ActW         = 2;
  localparam int unsigned StatW        = 3;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 7;

  localparam logic [CntW-1:0] CapacityReset = CntW'(64);

  typedef enum logic [ActW-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_PEEP = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_BADACT = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISCIPLINE = 1'b0,
    CFG_CAPACITY   = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic resp;
  } dp_cmd_t;

endpackage

[sv/bounded_stack_queue_engine.sv]
// Top level of the bounded stack and queue engine.
// The block holds signed 32-bit words and serves them as a stack or a queue.
// Input channel: an operation (action_i, push_value_i, position_i) transfers
// at a rising edge where start_i is high and busy_o is low.
// Result channel: done_o is high for exactly one cycle, the cycle after the
// transfer, with data_out_o, status_o and count_out_o valid alongside it.
// The receiver cannot stall; it must take the result in that cycle.
// The word store has a registered read port, and busy_o stays high while
// the result is shown, so no new operation is accepted until the result
// strobe has passed.
// Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
// cfg_idx_i (0 selects the discipline, 1 the capacity) at the next edge.
// Write configuration only while no operation is in flight.
// Reset (rst_ni low, asynchronous) empties the store, selects stack mode
// and sets the capacity to 64. The store itself is not cleared: only words
// that were pushed are ever read back, so no clearing pass is needed.
`timescale 1ns / 1ps
module bounded_stack_queue_engine
  import bsqe_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic        [ActW-1:0]     action_i,
  input  logic signed [DataW-1:0]    push_value_i,
  input  logic        [CntW-1:0]     position_i,
  input  logic                       cfg_we_i,
  input  logic        [CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [CfgDataW-1:0] cfg_wdata_i,
  output logic                       done_o,
  output logic signed [DataW-1:0]    data_out_o,
  output logic        [StatW-1:0]    status_o,
  output logic        [CntW-1:0]     count_out_o
);

  // The controller sequences each transfer; the datapath owns the word store, pointers and configuration.
  dp_cmd_t cmd;

  bsqe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  bsqe_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .position_i   (position_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .count_out_o  (count_out_o)
  );

endmodule

[sv/bsqe_ctrl.sv]
// Controller state machine of the bounded stack and queue engine.
`timescale 1ns / 1ps
module bsqe_ctrl
  import bsqe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   exec;

  assign exec = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (exec) begin
            state_q <= S_RESP;
            busy_q  <= 1'b1;
            done_q  <= 1'b1;
          end
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign cmd_o.exec = exec;
  assign cmd_o.resp = done_q;

endmodule

[sv/bsqe_dp.sv]
// Datapath of the bounded stack and queue engine: registers, pointers and word store.
`timescale 1ns / 1ps
module bsqe_dp
  import bsqe_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic                       cfg_we_i,
  input  logic        [CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [CfgDataW-1:0] cfg_wdata_i,
  input  logic        [ActW-1:0]     action_i,
  input  logic signed [DataW-1:0]    push_value_i,
  input  logic        [CntW-1:0]     position_i,
  output logic signed [DataW-1:0]    data_out_o,
  output logic        [StatW-1:0]    status_o,
  output logic        [CntW-1:0]     count_out_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned SumW = ((AW > CntW) ? AW : CntW) + 1;
  localparam logic [CntW-1:0] LimCap = CntW'((DEPTH < 127) ? DEPTH : 127);

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rd_data_q;

  logic                discipline_q;
  logic [CntW-1:0]     capacity_q;
  logic [AW-1:0]       front_q, front_d;
  logic [CntW-1:0]     count_q, count_d;
  status_e             status_q, status_d;
  logic                use_q, use_d;

  logic [CntW-1:0]     limit;
  logic [CntW-1:0]     offset;
  logic [SumW-1:0]     sum;
  logic [SumW-1:0]     sum_wrap;
  logic [AW-1:0]       addr;
  logic                wr_en;
  logic                queue_mode;

  assign queue_mode = discipline_q;
  assign limit      = (capacity_q > LimCap) ? LimCap : capacity_q;

  // Slot of an offset from the front, wrapped once: the front stays below DEPTH and the offset at most DEPTH.
  assign sum      = SumW'(front_q) + SumW'(offset);
  assign sum_wrap = (sum >= SumW'(DEPTH)) ? (sum - SumW'(DEPTH)) : sum;
  assign addr     = sum_wrap[AW-1:0];

  always_comb begin
    offset   = count_q;
    front_d  = front_q;
    count_d  = count_q;
    status_d = ST_OK;
    use_d    = 1'b0;
    wr_en    = 1'b0;
    unique case (action_e'(action_i))
      ACT_PUSH: begin
        if (count_q >= limit) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (queue_mode) begin
          offset  = '0;
          front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
          count_d = count_q - 1'b1;
          use_d   = 1'b1;
        end else begin
          offset  = count_q - 1'b1;
          count_d = count_q - 1'b1;
          use_d   = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (queue_mode) begin
          status_d = ST_BADACT;
        end else if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          offset = count_q - 1'b1;
          use_d  = 1'b1;
        end
      end
      ACT_PEEP: begin
        if (queue_mode) begin
          status_d = ST_BADACT;
        end else if (position_i == '0 || position_i > count_q) begin
          status_d = ST_BADPOS;
        end else begin
          offset = count_q - position_i;
          use_d  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discipline_q <= 1'b0;
      capacity_q   <= CapacityReset;
      front_q      <= '0;
      count_q      <= '0;
      status_q     <= ST_OK;
      use_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_DISCIPLINE: discipline_q <= cfg_wdata_i[0];
          CFG_CAPACITY:   capacity_q   <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.exec) begin
        front_q  <= front_d;
        count_q  <= count_d;
        status_q <= status_d;
        use_q    <= use_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem[addr] <= push_value_i;
      end
      rd_data_q <= mem[addr];
    end
  end

  assign data_out_o  = (cmd_i.resp && use_q) ? rd_data_q : '0;
  assign status_o    = status_q;
  assign count_out_o = count_q;

endmodule

[sv/bsqe_checker.sv]
// Port-level assertions of the bounded stack and queue engine and their bind.
`timescale 1ns / 1ps
`include "bounded_stack_queue_engine_macros.svh"
module bsqe_checker
  import bsqe_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic signed [DataW-1:0]    data_out_o,
  input logic        [StatW-1:0]    status_o,
  input logic        [CntW-1:0]     count_out_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  `BSQE_ASSERT_NEXT(a_accept_done, clk_i, rst_ni, accept, done_o, "no result after transfer")
  `BSQE_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held twice")
  `BSQE_ASSERT_NOW(a_bad_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), data_out_o == '0, "nonzero data on failed operation")
  `BSQE_ASSERT_NEXT(a_count_idle, clk_i, rst_ni, !accept, $stable(count_out_o), "count moved without a transfer")
  `BSQE_ASSERT_NOW(a_full_count, clk_i, rst_ni, done_o && (status_o == ST_FULL), $stable(count_out_o), "count moved on a full push")

endmodule

bind bounded_stack_queue_engine bsqe_checker u_bsqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .data_out_o  (data_out_o),
  .status_o    (status_o),
  .count_out_o (count_out_o)
);
